// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int Depth  = 16;
  localparam int DataW  = 32;
  localparam int PrioW  = 16;
  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StRemoved  = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic             valid;
    logic             keep;   // valid and priority >= incoming priority
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } spq_cell_t;

  // Broadcast request to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } spq_cmd_t;

endpackage

// ===== rtl/sorted_priority_queue_unit.sv =====
// A request is answered in the cycle after it is taken, done_o high for one cycle.
// Throughput: one request per cycle; every cell compares and shifts in the same cycle.
// busy is held low, so back-to-back requests are always taken.
// Reset (rst_ni low, asynchronous) empties the queue; stored words are not cleared.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              operation_i,
  input  logic [DataW-1:0]  entry_data_i,
  input  logic [PrioW-1:0]  entry_priority_i,
  output logic              done_o,
  output logic [DataW-1:0]  result_data_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] entry_count_o
);

  spq_cell_t        cell_st [Depth];
  spq_cmd_t         cmd;
  logic             accept, full, empty;
  logic [CountW-1:0] occupancy_q, occupancy_d;
  logic             done_q;
  logic [DataW-1:0] result_data_q, result_data_d;
  status_e          status_q, status_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (occupancy_q == CountW'(Depth));
  assign empty  = (occupancy_q == '0);

  assign cmd.ins  = accept && (op_e'(operation_i) == OpInsert) && !full;
  assign cmd.rem  = accept && (op_e'(operation_i) == OpRemove) && !empty;
  assign cmd.data = entry_data_i;
  assign cmd.prio = entry_priority_i;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    spq_cell_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '{valid: 1'b1, keep: 1'b1, data: '0, prio: '0};
    end else begin : g_mid
      assign left_w = cell_st[g-1];
    end
    if (g == Depth - 1) begin : g_tail
      assign right_w = '{valid: 1'b0, keep: 1'b0, data: '0, prio: '0};
    end else begin : g_body
      assign right_w = cell_st[g+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .state_o (cell_st[g])
    );
  end

  always_comb begin
    occupancy_d   = occupancy_q;
    result_data_d = '0;
    status_d      = StInserted;
    if (op_e'(operation_i) == OpInsert) begin
      if (full) begin
        status_d = StFull;
      end else begin
        status_d    = StInserted;
        occupancy_d = occupancy_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = StEmpty;
      end else begin
        status_d      = StRemoved;
        result_data_d = cell_st[0].data;
        occupancy_d   = occupancy_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupancy_q <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        occupancy_q <= occupancy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_data_q <= result_data_d;
      status_q      <= status_d;
    end
  end

  assign done_o        = done_q;
  assign result_data_o = result_data_q;
  assign status_o      = status_q;
  assign entry_count_o = occupancy_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_q <= CountW'(Depth))
    else $error("occupancy above depth");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty == !cell_st[0].valid)
    else $error("head cell valid disagrees with occupancy");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full == cell_st[Depth-1].valid)
    else $error("tail cell valid disagrees with occupancy");

  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request not answered");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StEmpty || status_o == StFull) |-> result_data_o == '0)
    else $error("refused request carries data");

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  spq_cmd_t  cmd_i,
  input  spq_cell_t left_i,
  input  spq_cell_t right_i,
  output spq_cell_t state_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] data_q, data_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic             keep;

  assign keep = valid_q && (prio_q >= cmd_i.prio);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (cmd_i.ins && !keep) begin
      if (left_i.keep) begin
        // first cell behind every entry of equal or higher priority
        valid_d = 1'b1;
        data_d  = cmd_i.data;
        prio_d  = cmd_i.prio;
      end else begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
        prio_d  = left_i.prio;
      end
    end else if (cmd_i.rem) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
      prio_d  = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign state_o = '{valid: valid_q, keep: keep, data: data_q, prio: prio_q};

endmodule

// ===== sim/spq_order_checker.sv =====
`timescale 1ns / 1ps

module spq_order_checker import spq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic              operation_i,
  input  logic [DataW-1:0]  entry_data_i,
  input  logic [PrioW-1:0]  entry_priority_i,
  input  logic              done_o,
  input  logic [DataW-1:0]  result_data_o,
  input  logic [1:0]        status_o,
  input  logic [CountW-1:0] entry_count_o,
  output int                mismatch_count_o,
  output int                awaited_count_o
);

  typedef struct {
    logic [DataW-1:0]  data;
    status_e           status;
    logic [CountW-1:0] count;
  } queue_result_t;

  // Model of the queue contents, front entry at index 0
  logic [DataW-1:0] held_data [Depth];
  logic [PrioW-1:0] held_prio [Depth];
  int               held_count;

  queue_result_t awaited_results [$];
  int            mismatches = 0;

  task automatic report_mismatch(input string line);
    $display("%0t ns: %s", $time, line);
    mismatches++;
  endtask

  task automatic apply_request(input op_e op, input logic [DataW-1:0] data,
                               input logic [PrioW-1:0] prio, output queue_result_t res);
    int pos;
    res.data = '0;
    if (op == OpInsert) begin
      if (held_count >= Depth) begin
        res.status = StFull;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_count && held_prio[pos] >= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = data;
        held_prio[pos] = prio;
        held_count++;
        res.status = StInserted;
      end
    end else if (held_count == 0) begin
      res.status = StEmpty;
    end else begin
      res.data = held_data[0];
      for (int i = 1; i < held_count; i++) begin
        held_data[i-1] = held_data[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
      res.status = StRemoved;
    end
    res.count = held_count[CountW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    queue_result_t fresh;
    if (!rst_ni) begin
      held_count = 0;
      awaited_results.delete();
      awaited_count_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      // result of the previous cycle's request is checked before a new one is taken
      if (done_o === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: data %0h status %0d",
                                    result_data_o, status_o));
        end else begin
          want = awaited_results.pop_front();
          if (result_data_o !== want.data)
            report_mismatch($sformatf("result_data mismatch: got %0h, expected %0h",
                                      result_data_o, want.data));
          if (status_o !== want.status)
            report_mismatch($sformatf("status mismatch: got %0d, expected %0d",
                                      status_o, want.status));
          if (entry_count_o !== want.count)
            report_mismatch($sformatf("entry_count mismatch: got %0d, expected %0d",
                                      entry_count_o, want.count));
        end
      end else if (done_o !== 1'b0) begin
        report_mismatch("done_o is unknown");
      end
      if (start && !busy) begin
        apply_request(op_e'(operation_i), entry_data_i, entry_priority_i, fresh);
        awaited_results.push_back(fresh);
      end
      awaited_count_o <= awaited_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== sim/sorted_priority_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 900;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              operation_i;
  logic [DataW-1:0]  entry_data_i;
  logic [PrioW-1:0]  entry_priority_i;
  logic              done_o;
  logic [DataW-1:0]  result_data_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] entry_count_o;

  int mismatch_count;
  int awaited_count;
  int cycles = 0;

  sorted_priority_queue_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .entry_data_i     (entry_data_i),
    .entry_priority_i (entry_priority_i),
    .done_o           (done_o),
    .result_data_o    (result_data_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o)
  );

  spq_order_checker order_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .entry_data_i     (entry_data_i),
    .entry_priority_i (entry_priority_i),
    .done_o           (done_o),
    .result_data_o    (result_data_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("sorted_priority_queue_unit test failed");
      $finish;
    end
  end

  // Called just after a rising edge; returns at the edge that takes the request.
  // start is left high so a back-to-back request needs no second assignment.
  task automatic submit_request(input op_e op, input logic [DataW-1:0] data,
                                input logic [PrioW-1:0] prio, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    operation_i      <= op;
    entry_data_i     <= data;
    entry_priority_i <= prio;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // narrow ranges give plenty of equal priorities, so arrival order gets tested
  function automatic logic [PrioW-1:0] pick_prio(input int spread);
    case (spread)
      0:       return PrioW'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return PrioW'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int burst_len;
    int insert_pct;
    int spread;
    int issued;
    bit quiet;
    op_e op;

    rst_ni           = 1'b0;
    start            = 1'b0;
    operation_i      = OpInsert;
    entry_data_i     = '0;
    entry_priority_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, ties, fill to full, refused insert
    submit_request(OpRemove, '1, '1, 0);
    submit_request(OpInsert, '0, '0, 0);
    submit_request(OpInsert, '1, '1, 1);
    submit_request(OpInsert, 32'ha5a5_5a5a, '1, 0);
    submit_request(OpInsert, 32'h0000_0001, '0, 3);
    for (int i = 0; i < 12; i++)
      submit_request(OpInsert, $urandom, (i % 3 == 0) ? 16'd100 : 16'd7, i % 2);
    submit_request(OpInsert, 32'hdead_beef, 16'hffff, 0);
    for (int i = 0; i < 5; i++)
      submit_request(OpRemove, '0, '0, i % 2);
    wait_drained();

    issued = 0;
    while (issued < RandomItems) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      spread = $urandom_range(0, 3);
      quiet  = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < burst_len; k++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpRemove;
        submit_request(op, pick_data(), pick_prio(spread), quiet ? 0 : $urandom_range(0, 11));
        issued++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_unit test passed");
    end else begin
      $display("sorted_priority_queue_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
sim/spq_order_checker.sv
sim/sorted_priority_queue_unit_tb.sv
